// ----- rtl/plt_pkg.sv -----
// shared constants, command codes and types of the pareto label table
package plt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int M2_BITS = 32;
	localparam int FIELD_W = 10;
	localparam int PORT_M2_W = 32;
	localparam int SCAN_W = FIELD_W + 1;
	localparam int EPOCH_W = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] CMD_EXTEND = 2'd0;
	localparam logic [1:0] CMD_ROUND = 2'd1;
	localparam logic [1:0] CMD_SCAN = 2'd2;
	localparam logic [1:0] CMD_SEARCH = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_M1 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_M2 = 1'b1;

	localparam logic [FIELD_W-1:0] LIMIT_M1_RESET = 10'd1023;
	localparam logic [PORT_M2_W-1:0] LIMIT_M2_RESET = 32'hFFFF_FFFE;

	localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_REBASED = EPOCH_W'(2);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

	localparam int OP_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_NOP = 3'd0,
		OP_EXT = 3'd1,
		OP_SCAN = 3'd2,
		OP_DONE = 3'd3,
		OP_ROUND = 3'd4,
		OP_SEARCH = 3'd5
	} op_t;

endpackage

// ----- rtl/plt_ram.sv -----
// generic single write port, single read port ram with registered read
module plt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/plt_queue.sv -----
// small fifo between the front and back parts
module plt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CNT_W'(DEPTH));
	assign dout = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

// ----- rtl/plt_front.sv -----
// front part: takes commands, forms label sums, checks limits, walks the scan index
module plt_front #(
	parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH,
	parameter int M2_BITS = plt_pkg::M2_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [1:0]                          cmd,
	input  logic [plt_pkg::FIELD_W-1:0]         path_m1,
	input  logic [plt_pkg::PORT_M2_W-1:0]       path_m2,
	input  logic [plt_pkg::FIELD_W-1:0]         edge_m1,
	input  logic [plt_pkg::PORT_M2_W-1:0]       edge_m2,
	input  logic [plt_pkg::FIELD_W-1:0]         source_node,
	input  logic [plt_pkg::FIELD_W-1:0]         limit_m1,
	input  logic [M2_BITS-1:0]                  limit_m2,
	output logic                                push,
	output plt_pkg::op_t                        op,
	output logic [$clog2(TABLE_DEPTH)-1:0]      idx,
	output logic [M2_BITS-1:0]                  m2,
	output logic [plt_pkg::FIELD_W-1:0]         pred
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [plt_pkg::SCAN_W-1:0] scan_q;
	logic [plt_pkg::SCAN_W-1:0] d1;
	logic [M2_BITS:0]           d2;
	logic                       fits;
	logic                       scan_end;

	assign d1 = {1'b0, path_m1} + {1'b0, edge_m1};
	assign d2 = {1'b0, M2_BITS'(path_m2)} + {1'b0, M2_BITS'(edge_m2)};
	assign fits = (d1 <= {1'b0, limit_m1}) && (32'(d1) < 32'(TABLE_DEPTH))
		&& (d2 <= {1'b0, limit_m2});
	assign scan_end = (scan_q > {1'b0, limit_m1}) || (32'(scan_q) >= 32'(TABLE_DEPTH));
	assign push = accept;

	always_comb begin
		op = plt_pkg::OP_NOP;
		idx = '0;
		m2 = d2[M2_BITS-1:0];
		pred = source_node;
		case (cmd)
			plt_pkg::CMD_EXTEND: begin
				op = fits ? plt_pkg::OP_EXT : plt_pkg::OP_NOP;
				idx = IDX_W'(d1);
			end
			plt_pkg::CMD_ROUND: begin
				op = plt_pkg::OP_ROUND;
			end
			plt_pkg::CMD_SCAN: begin
				op = scan_end ? plt_pkg::OP_DONE : plt_pkg::OP_SCAN;
				idx = IDX_W'(scan_q);
			end
			plt_pkg::CMD_SEARCH: begin
				op = plt_pkg::OP_SEARCH;
			end
			default: begin
				op = plt_pkg::OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (accept) begin
			if (cmd == plt_pkg::CMD_ROUND || cmd == plt_pkg::CMD_SEARCH) begin
				scan_q <= '0;
			end else if (cmd == plt_pkg::CMD_SCAN && !scan_end) begin
				scan_q <= scan_q + plt_pkg::SCAN_W'(1);
			end
		end
	end

endmodule

// ----- rtl/plt_back.sv -----
// back part: table read-modify-write, front tracking, epoch tags and tag rebase sweep
module plt_back #(
	parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH,
	parameter int M2_BITS = plt_pkg::M2_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  plt_pkg::op_t                       q_op,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     q_idx,
	input  logic [M2_BITS-1:0]                 q_m2,
	input  logic [plt_pkg::FIELD_W-1:0]        q_pred,
	output logic                               q_pop,
	output logic                               sweep_busy,
	output logic                               result_strobe,
	output logic                               improved,
	output logic                               on_front,
	output logic                               extendable,
	output logic [plt_pkg::FIELD_W-1:0]        point_m1,
	output logic [plt_pkg::PORT_M2_W-1:0]      point_m2,
	output logic [plt_pkg::FIELD_W-1:0]        point_pred,
	output logic                               scan_done
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int DATA_W = M2_BITS + plt_pkg::FIELD_W;
	localparam int EW = plt_pkg::EPOCH_W;
	localparam logic [M2_BITS:0] M2_INF = {1'b1, {M2_BITS{1'b0}}};

	// stage 1 op
	logic                        v_s1;
	plt_pkg::op_t                op_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [M2_BITS-1:0]          m2_s1;
	logic [plt_pkg::FIELD_W-1:0] pred_s1;

	// last table write, forwarded to the next op
	logic                        fwd_v_q;
	logic [IDX_W-1:0]            fwd_idx_q;
	logic [M2_BITS-1:0]          fwd_m2_q;
	logic [plt_pkg::FIELD_W-1:0] fwd_pred_q;
	logic [EW-1:0]               fwd_tag_q;

	logic [EW-1:0]               cur_q;
	logic [EW-1:0]               start_q;
	logic [M2_BITS:0]            last_front_q;

	logic                        sw_rd_act_q;
	logic                        sw_wr_v_q;
	logic                        sw_zero_q;
	logic                        sw_search_q;
	logic [IDX_W-1:0]            sw_idx_q;
	logic [IDX_W-1:0]            sw_wr_idx_q;

	logic [DATA_W-1:0]           data_rd;
	logic [EW-1:0]               tag_rd;
	logic [IDX_W-1:0]            tag_raddr;
	logic                        tag_we;
	logic [IDX_W-1:0]            tag_waddr;
	logic [EW-1:0]               tag_wdata;
	logic [EW-1:0]               sw_tag;

	logic                        hit;
	logic [M2_BITS-1:0]          ent_m2;
	logic [plt_pkg::FIELD_W-1:0] ent_pred;
	logic [EW-1:0]               ent_tag;
	logic                        ent_valid;
	logic                        ent_cand;
	logic                        is_clear;
	logic                        wrap;
	logic                        is_scan;
	logic                        front_hit;
	logic                        ext_wr;

	assign is_clear = v_s1 && (op_s1 == plt_pkg::OP_ROUND || op_s1 == plt_pkg::OP_SEARCH);
	assign wrap = is_clear && (cur_q == plt_pkg::EPOCH_MAX);
	assign sweep_busy = sw_rd_act_q || sw_wr_v_q;
	assign q_pop = !q_empty && !sweep_busy && !wrap;

	assign hit = fwd_v_q && (fwd_idx_q == idx_s1);
	assign ent_m2 = hit ? fwd_m2_q : data_rd[DATA_W-1:plt_pkg::FIELD_W];
	assign ent_pred = hit ? fwd_pred_q : data_rd[plt_pkg::FIELD_W-1:0];
	assign ent_tag = hit ? fwd_tag_q : tag_rd;
	assign ent_valid = (ent_tag != plt_pkg::EPOCH_NONE) && (ent_tag >= start_q);
	assign ent_cand = (ent_tag == cur_q);

	assign is_scan = v_s1 && (op_s1 == plt_pkg::OP_SCAN);
	assign front_hit = is_scan && ent_valid && ({1'b0, ent_m2} < last_front_q);
	assign ext_wr = v_s1 && (op_s1 == plt_pkg::OP_EXT) && (!ent_valid || ent_m2 > m2_s1);

	// live entries keep a base tag, not candidates, stale ones drop out
	assign sw_tag = (!sw_zero_q && tag_rd != plt_pkg::EPOCH_NONE && tag_rd >= start_q)
		? plt_pkg::EPOCH_FIRST : plt_pkg::EPOCH_NONE;

	assign tag_raddr = sw_rd_act_q ? sw_idx_q : q_idx;
	assign tag_we = ext_wr || sw_wr_v_q;
	assign tag_waddr = sw_wr_v_q ? sw_wr_idx_q : idx_s1;
	assign tag_wdata = sw_wr_v_q ? sw_tag : cur_q;

	plt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_DEPTH)
	) u_data_ram (
		.clk(clk),
		.we(ext_wr),
		.waddr(idx_s1),
		.wdata({m2_s1, pred_s1}),
		.raddr(q_idx),
		.rdata(data_rd)
	);

	plt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_tag_ram (
		.clk(clk),
		.we(tag_we),
		.waddr(tag_waddr),
		.wdata(tag_wdata),
		.raddr(tag_raddr),
		.rdata(tag_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
			result_strobe <= 1'b0;
			cur_q <= plt_pkg::EPOCH_FIRST;
			start_q <= plt_pkg::EPOCH_FIRST;
			last_front_q <= M2_INF;
			sw_rd_act_q <= 1'b1;
			sw_wr_v_q <= 1'b0;
			sw_zero_q <= 1'b1;
			sw_search_q <= 1'b0;
			sw_idx_q <= '0;
			sw_wr_idx_q <= '0;
		end else begin
			v_s1 <= q_pop;
			fwd_v_q <= ext_wr;
			result_strobe <= v_s1;

			if (is_clear) begin
				last_front_q <= M2_INF;
			end else if (front_hit) begin
				last_front_q <= {1'b0, ent_m2};
			end

			if (is_clear && !wrap) begin
				cur_q <= cur_q + EW'(1);
				if (op_s1 == plt_pkg::OP_SEARCH) begin
					start_q <= cur_q + EW'(1);
				end
			end else if (sw_wr_v_q && !sw_rd_act_q && !sw_zero_q) begin
				cur_q <= plt_pkg::EPOCH_REBASED;
				start_q <= sw_search_q ? plt_pkg::EPOCH_REBASED : plt_pkg::EPOCH_FIRST;
			end

			if (wrap) begin
				sw_rd_act_q <= 1'b1;
				sw_zero_q <= 1'b0;
				sw_search_q <= (op_s1 == plt_pkg::OP_SEARCH);
				sw_idx_q <= '0;
			end else if (sw_rd_act_q) begin
				sw_idx_q <= sw_idx_q + IDX_W'(1);
				if (sw_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
					sw_rd_act_q <= 1'b0;
				end
			end
			sw_wr_v_q <= sw_rd_act_q;
			sw_wr_idx_q <= sw_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1 <= q_op;
			idx_s1 <= q_idx;
			m2_s1 <= q_m2;
			pred_s1 <= q_pred;
		end
		fwd_idx_q <= idx_s1;
		fwd_m2_q <= m2_s1;
		fwd_pred_q <= pred_s1;
		fwd_tag_q <= cur_q;
		if (v_s1) begin
			improved <= ext_wr;
			on_front <= front_hit;
			extendable <= front_hit && ent_cand;
			point_m1 <= is_scan ? plt_pkg::FIELD_W'(idx_s1) : '0;
			point_m2 <= (is_scan && ent_valid) ? plt_pkg::PORT_M2_W'(ent_m2) : '0;
			point_pred <= (is_scan && ent_valid) ? ent_pred : '0;
			scan_done <= (op_s1 == plt_pkg::OP_DONE);
		end
	end

	a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |-> !q_pop)
		else $error("op taken from queue during tag sweep");

	a_one_tag_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ext_wr && sw_wr_v_q))
		else $error("table update collides with tag sweep");

	a_epoch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != plt_pkg::EPOCH_NONE) && (start_q <= cur_q))
		else $error("epoch counters out of order");

	a_front_reset: assert property (@(posedge clk) disable iff (!arst_n)
		is_clear |=> (last_front_q == M2_INF))
		else $error("front bound not reset by new round");

endmodule

// ----- rtl/pareto_label_table.sv -----
// top level of the pareto label table: limit registers, front part, queue and back part
// a result strobes from the output registers after its op has passed the queue and the stage 1 registers
// throughput: one item per cycle while busy is low; the 255th new round or new search, then every 254th,
//   stops the back part while the round tags are swept
// reset: a tag clearing pass over all TABLE_DEPTH entries runs with busy high
// results cannot be held off; each strobes for exactly one cycle
module pareto_label_table #(
	parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH,
	parameter int M2_BITS = plt_pkg::M2_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           cmd,
	input  logic [plt_pkg::FIELD_W-1:0]          path_m1,
	input  logic [plt_pkg::PORT_M2_W-1:0]        path_m2,
	input  logic [plt_pkg::FIELD_W-1:0]          edge_m1,
	input  logic [plt_pkg::PORT_M2_W-1:0]        edge_m2,
	input  logic [plt_pkg::FIELD_W-1:0]          source_node,
	output logic                                 result_strobe,
	output logic                                 improved,
	output logic                                 on_front,
	output logic                                 extendable,
	output logic [plt_pkg::FIELD_W-1:0]          point_m1,
	output logic [plt_pkg::PORT_M2_W-1:0]        point_m2,
	output logic [plt_pkg::FIELD_W-1:0]          point_pred,
	output logic                                 scan_done,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [plt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [plt_pkg::PORT_M2_W-1:0]        cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = plt_pkg::OP_W + IDX_W + M2_BITS + plt_pkg::FIELD_W;

	logic [plt_pkg::FIELD_W-1:0] limit_m1_q;
	logic [M2_BITS-1:0]          limit_m2_q;

	logic                        accept;
	logic                        push;
	plt_pkg::op_t                f_op;
	logic [IDX_W-1:0]            f_idx;
	logic [M2_BITS-1:0]          f_m2;
	logic [plt_pkg::FIELD_W-1:0] f_pred;
	logic [ENTRY_W-1:0]          q_dout;
	logic                        q_empty;
	logic                        q_full;
	logic                        q_pop;
	logic                        sweep_busy;

	assign cfg_ready = 1'b1;
	assign busy = q_full || sweep_busy;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_m1_q <= plt_pkg::LIMIT_M1_RESET;
			limit_m2_q <= M2_BITS'(plt_pkg::LIMIT_M2_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				plt_pkg::CFG_LIMIT_M1: begin
					limit_m1_q <= cfg_data[plt_pkg::FIELD_W-1:0];
				end
				plt_pkg::CFG_LIMIT_M2: begin
					limit_m2_q <= M2_BITS'(cfg_data);
				end
				default: begin
					limit_m1_q <= limit_m1_q;
				end
			endcase
		end
	end

	plt_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.M2_BITS(M2_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(cmd),
		.path_m1(path_m1),
		.path_m2(path_m2),
		.edge_m1(edge_m1),
		.edge_m2(edge_m2),
		.source_node(source_node),
		.limit_m1(limit_m1_q),
		.limit_m2(limit_m2_q),
		.push(push),
		.op(f_op),
		.idx(f_idx),
		.m2(f_m2),
		.pred(f_pred)
	);

	plt_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(plt_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din({f_op, f_idx, f_m2, f_pred}),
		.pop(q_pop),
		.dout(q_dout),
		.empty(q_empty),
		.full(q_full)
	);

	plt_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.M2_BITS(M2_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_op(plt_pkg::op_t'(q_dout[ENTRY_W-1 -: plt_pkg::OP_W])),
		.q_idx(q_dout[M2_BITS + plt_pkg::FIELD_W +: IDX_W]),
		.q_m2(q_dout[plt_pkg::FIELD_W +: M2_BITS]),
		.q_pred(q_dout[plt_pkg::FIELD_W-1:0]),
		.q_pop(q_pop),
		.sweep_busy(sweep_busy),
		.result_strobe(result_strobe),
		.improved(improved),
		.on_front(on_front),
		.extendable(extendable),
		.point_m1(point_m1),
		.point_m2(point_m2),
		.point_pred(point_pred),
		.scan_done(scan_done)
	);

endmodule
